// ===== rtl/srcr_pkg.sv =====
// Shared types and constants for the shift, rotate, compare and CR unit.
`timescale 1ns / 1ps

package srcr_pkg;

	// Depth of the queue between the decode front and the execute back.
	localparam int QUEUE_DEPTH = 2;

	// Action codes carried in the input beat.
	localparam logic [3:0] ACT_SLL       = 4'd0;
	localparam logic [3:0] ACT_SRL       = 4'd1;
	localparam logic [3:0] ACT_SRA       = 4'd2;
	localparam logic [3:0] ACT_ROTL      = 4'd3;
	localparam logic [3:0] ACT_MASK      = 4'd4;
	localparam logic [3:0] ACT_CMP_S     = 4'd5;
	localparam logic [3:0] ACT_CMP_U     = 4'd6;
	localparam logic [3:0] ACT_CR0_REC   = 4'd7;
	localparam logic [3:0] ACT_GET_FIELD = 4'd8;
	localparam logic [3:0] ACT_SET_FIELD = 4'd9;
	localparam logic [3:0] ACT_GET_BIT   = 4'd10;
	localparam logic [3:0] ACT_SET_BIT   = 4'd11;
	localparam logic [3:0] ACT_WR_XER    = 4'd12;

	// XER bit positions (little-endian numbering).
	localparam int XER_SO_BIT = 31;
	localparam int XER_CA_BIT = 29;

	// Operation class handed from the front to the back.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_RESULT,
		OP_SRA,
		OP_CMP,
		OP_GET_FIELD,
		OP_SET_FIELD,
		OP_GET_BIT,
		OP_SET_BIT,
		OP_XER
	} srcr_op_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [4:0]  shift_amount;
		logic [4:0]  mask_first;
		logic [4:0]  mask_last;
		logic [2:0]  field_sel;
		logic [4:0]  bit_sel;
		logic [3:0]  field_value;
		logic        bit_value;
	} srcr_item_t;

	typedef struct packed {
		logic [31:0] result;
		logic [31:0] cr_value;
		logic [31:0] xer_value;
	} srcr_res_t;

	// Decoded queue entry. rel holds the less, greater and equal flags.
	typedef struct packed {
		srcr_op_t    op;
		logic [31:0] data;
		logic [2:0]  rel;
		logic        carry;
		logic [2:0]  field_idx;
		logic [4:0]  bit_idx;
		logic [3:0]  field_val;
		logic        bit_val;
	} srcr_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} srcr_q_status_t;

endpackage

// ===== rtl/ppc_shift_rotate_compare_cr_unit.sv =====
// Top level of the shift, rotate, compare and CR unit.
// Input channel item_valid / item_ready / item carries one operation per beat:
// shifts, rotate and mask generation, compares into a CR field, CR0 record,
// CR field and bit access, and XER writes. The output channel
// res_valid / res_ready / res returns one beat per input beat, in order, with
// the result and the CR and XER values as they stand after that operation.
// The front decodes a beat and computes the shift, rotate, mask and compare
// outcomes in the cycle it is accepted, then writes it to a queue of Depth
// entries. The back takes the queue head, updates CR and XER and loads the
// output register. An accepted beat is written into the queue and then into the
// output register before it appears on res. While the receiver does not stall,
// throughput is one beat per cycle, set by the single CR/XER update in the back.
// When the receiver stalls, the output register holds its beat,
// the back stops, and item_ready drops once the queue is full.
// Reset clears CR, XER, the queue and the output valid.
`timescale 1ns / 1ps

module ppc_shift_rotate_compare_cr_unit import srcr_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  srcr_item_t item,
	output logic       res_valid,
	input  logic       res_ready,
	output srcr_res_t  res
);

	srcr_q_status_t q_status;
	srcr_entry_t    push_entry;
	srcr_entry_t    head_entry;
	logic           push;
	logic           pop;
	logic           head_valid;

	srcr_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.entry      (push_entry)
	);

	srcr_queue #(
		.Depth (Depth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.status     (q_status)
	);

	srcr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// The queue can never be full and empty at once.
	a_q_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue reports full and empty together");

	// An accepted beat leaves the queue non-empty or is already on its way out.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !q_status.empty)
		else $error("accepted beat missing from queue");

	// Every entry taken by the back shows up as an output beat.
	a_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> res_valid)
		else $error("executed entry produced no output beat");

	// A stalled output beat must block the back.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !pop)
		else $error("back advanced over a stalled output beat");

endmodule

// ===== rtl/srcr_front.sv =====
// Decode front: accepts input beats, computes data-only results and classifies.
`timescale 1ns / 1ps

module srcr_front import srcr_pkg::*; (
	input  logic           item_valid,
	output logic           item_ready,
	input  srcr_item_t     item,
	input  srcr_q_status_t q_status,
	output logic           push,
	output srcr_entry_t    entry
);

	logic [31:0] a;
	logic [31:0] b;
	logic [5:0]  ls;
	logic [31:0] sll_res;
	logic [31:0] srl_res;
	logic [31:0] sra_res;
	logic [31:0] lost;
	logic [63:0] rot_w;
	logic [31:0] mask_lo;
	logic [31:0] mask_hi;
	logic [31:0] mask_res;
	logic        lt_s;
	logic        lt_u;
	logic        eq;

	assign item_ready = !q_status.full;
	assign push       = item_valid && item_ready;

	assign a  = item.value_a;
	assign b  = item.value_b;
	assign ls = b[5:0];

	assign sll_res = ls[5] ? 32'd0 : (a << ls[4:0]);
	assign srl_res = ls[5] ? 32'd0 : (a >> ls[4:0]);
	assign sra_res = $unsigned($signed(a) >>> item.shift_amount);
	assign lost    = a & ~(32'hFFFF_FFFF << item.shift_amount);
	assign rot_w   = {a, a} << item.shift_amount;

	// Mask bits are numbered from the MSB; a begin past the end wraps round.
	assign mask_lo  = 32'hFFFF_FFFF >> item.mask_first;
	assign mask_hi  = ~(32'h7FFF_FFFF >> item.mask_last);
	assign mask_res = (item.mask_first <= item.mask_last) ? (mask_lo & mask_hi)
		: (mask_lo | mask_hi);

	assign lt_s = $signed(a) < $signed(b);
	assign lt_u = a < b;
	assign eq   = a == b;

	always_comb begin
		entry           = '0;
		entry.op        = OP_NONE;
		entry.field_idx = item.field_sel;
		entry.bit_idx   = item.bit_sel;
		entry.field_val = item.field_value;
		entry.bit_val   = item.bit_value;
		unique case (item.action)
			ACT_SLL: begin
				entry.op   = OP_RESULT;
				entry.data = sll_res;
			end
			ACT_SRL: begin
				entry.op   = OP_RESULT;
				entry.data = srl_res;
			end
			ACT_SRA: begin
				entry.op    = OP_SRA;
				entry.data  = sra_res;
				entry.carry = a[31] && (lost != 32'd0);
			end
			ACT_ROTL: begin
				entry.op   = OP_RESULT;
				entry.data = rot_w[63:32];
			end
			ACT_MASK: begin
				entry.op   = OP_RESULT;
				entry.data = mask_res;
			end
			ACT_CMP_S: begin
				entry.op  = OP_CMP;
				entry.rel = {lt_s, !lt_s && !eq, eq};
			end
			ACT_CMP_U: begin
				entry.op  = OP_CMP;
				entry.rel = {lt_u, !lt_u && !eq, eq};
			end
			ACT_CR0_REC: begin
				entry.op        = OP_CMP;
				entry.field_idx = 3'd0;
				entry.rel       = {a[31], !a[31] && (a != 32'd0), a == 32'd0};
			end
			ACT_GET_FIELD: entry.op = OP_GET_FIELD;
			ACT_SET_FIELD: entry.op = OP_SET_FIELD;
			ACT_GET_BIT:   entry.op = OP_GET_BIT;
			ACT_SET_BIT:   entry.op = OP_SET_BIT;
			ACT_WR_XER: begin
				entry.op   = OP_XER;
				entry.data = a;
			end
			default:       entry.op = OP_NONE;
		endcase
	end

endmodule

// ===== rtl/srcr_queue.sv =====
// Small FIFO of decoded entries between the front and the back.
`timescale 1ns / 1ps

module srcr_queue import srcr_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srcr_entry_t    push_entry,
	input  logic           pop,
	output logic           head_valid,
	output srcr_entry_t    head_entry,
	output srcr_q_status_t status
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	srcr_entry_t     mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign status.empty = count_q == CntW'(0);
	assign status.full  = count_q == CntW'(Depth);
	assign head_valid   = !status.empty;
	assign head_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ===== rtl/srcr_back.sv =====
// Execute back: holds CR and XER, applies each entry and registers the result beat.
`timescale 1ns / 1ps

module srcr_back import srcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  srcr_entry_t head_entry,
	output logic        pop,
	output logic        res_valid,
	input  logic        res_ready,
	output srcr_res_t   res
);

	logic [31:0] cr_q;
	logic [31:0] xer_q;
	logic [31:0] cr_nxt;
	logic [31:0] xer_nxt;
	logic [31:0] result;
	logic        wr_field;
	logic [3:0]  fld_val;
	logic [4:0]  fld_lsb;
	logic [4:0]  bit_pos;
	logic        out_valid_q;
	srcr_res_t   res_q;

	assign res_valid = out_valid_q;
	assign res       = res_q;
	assign pop       = head_valid && (!out_valid_q || res_ready);

	// Field 0 is the most significant nibble, bit 0 the most significant bit.
	assign fld_lsb = {3'd7 - head_entry.field_idx, 2'b00};
	assign bit_pos = 5'd31 - head_entry.bit_idx;

	always_comb begin
		cr_nxt   = cr_q;
		xer_nxt  = xer_q;
		result   = 32'd0;
		wr_field = 1'b0;
		fld_val  = head_entry.field_val;
		unique case (head_entry.op)
			OP_RESULT: result = head_entry.data;
			OP_SRA: begin
				result              = head_entry.data;
				xer_nxt[XER_CA_BIT] = head_entry.carry;
			end
			OP_CMP: begin
				wr_field = 1'b1;
				fld_val  = {head_entry.rel, xer_q[XER_SO_BIT]};
			end
			OP_SET_FIELD: wr_field = 1'b1;
			OP_GET_FIELD: result = {28'd0, cr_q[fld_lsb +: 4]};
			OP_GET_BIT:   result = {31'd0, cr_q[bit_pos]};
			OP_SET_BIT:   cr_nxt[bit_pos] = head_entry.bit_val;
			OP_XER:       xer_nxt = head_entry.data;
			default:      result = 32'd0;
		endcase
		for (int i = 0; i < 8; i++) begin
			if (wr_field && (head_entry.field_idx == 3'(i))) begin
				cr_nxt[(7 - i) * 4 +: 4] = fld_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q        <= '0;
			xer_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cr_q        <= cr_nxt;
				xer_q       <= xer_nxt;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.result    <= result;
			res_q.cr_value  <= cr_nxt;
			res_q.xer_value <= xer_nxt;
		end
	end

endmodule

// ===== sim/tb_ppc_shift_rotate_compare_cr_unit.sv =====
// Testbench for the shift, rotate, compare and CR unit, with a self-checking predictor.
`timescale 1ns / 1ps

module tb_ppc_shift_rotate_compare_cr_unit;
	import srcr_pkg::*;

	// Action codes that the unit must ignore.
	localparam logic [3:0] ACT_IDLE_FIRST = 4'd13;
	localparam logic [3:0] ACT_IDLE_LAST  = 4'd15;

	// Condition field codes.
	localparam logic [3:0] CR_LT = 4'd8;
	localparam logic [3:0] CR_GT = 4'd4;
	localparam logic [3:0] CR_EQ = 4'd2;

	localparam int RANDOM_BEATS = 410;
	localparam int HOLD_CYCLES  = 80;

	typedef struct {
		logic       drain;
		srcr_item_t beat;
	} queued_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	srcr_item_t item = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	srcr_res_t  res;

	queued_beat_t pending_beats[$];
	srcr_res_t    pending_results[$];

	logic [31:0] cr_model = '0;
	logic [31:0] xer_model = '0;

	logic item_fire = 1'b0;
	int unsigned cycle_cnt = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned beats_in = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned carry_sets = 0;
	int unsigned action_hits[16];

	ppc_shift_rotate_compare_cr_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #2 clk = ~clk;

	// Applies one beat to the CR/XER copy and returns the beat that the unit should send.
	function automatic srcr_res_t execute_action(srcr_item_t b);
		srcr_res_t   r;
		logic [5:0]  ls;
		logic [63:0] twice;
		logic [31:0] lost;
		logic [3:0]  flags;
		logic [4:0]  pos;
		logic [2:0]  tgt;
		logic        wr_flags;
		r = '0;
		ls = b.value_b[5:0];
		flags = '0;
		tgt = b.field_sel;
		wr_flags = 1'b0;
		case (b.action)
			ACT_SLL: r.result = (ls < 6'd32) ? (b.value_a << ls) : '0;
			ACT_SRL: r.result = (ls < 6'd32) ? (b.value_a >> ls) : '0;
			ACT_SRA: begin
				lost = b.value_a & ~(32'hFFFF_FFFF << b.shift_amount);
				r.result = $signed(b.value_a) >>> b.shift_amount;
				xer_model[XER_CA_BIT] = b.value_a[31] && (lost != '0);
			end
			ACT_ROTL: begin
				twice = {b.value_a, b.value_a} << b.shift_amount;
				r.result = twice[63:32];
			end
			ACT_MASK: begin
				// Walk from the first bit to the last, wrapping past bit 31.
				pos = b.mask_first;
				for (int n = 0; n < 32; n++) begin
					r.result[31 - pos] = 1'b1;
					if (pos == b.mask_last)
						break;
					pos = pos + 5'd1;
				end
			end
			ACT_CMP_S: begin
				wr_flags = 1'b1;
				flags = ($signed(b.value_a) < $signed(b.value_b)) ? CR_LT :
					($signed(b.value_a) > $signed(b.value_b)) ? CR_GT : CR_EQ;
			end
			ACT_CMP_U: begin
				wr_flags = 1'b1;
				flags = (b.value_a < b.value_b) ? CR_LT :
					(b.value_a > b.value_b) ? CR_GT : CR_EQ;
			end
			ACT_CR0_REC: begin
				wr_flags = 1'b1;
				tgt = '0;
				flags = b.value_a[31] ? CR_LT : (b.value_a != '0) ? CR_GT : CR_EQ;
			end
			ACT_GET_FIELD: r.result = {28'b0, cr_model[(7 - b.field_sel) * 4 +: 4]};
			ACT_SET_FIELD: cr_model[(7 - b.field_sel) * 4 +: 4] = b.field_value;
			ACT_GET_BIT: r.result = {31'b0, cr_model[31 - b.bit_sel]};
			ACT_SET_BIT: cr_model[31 - b.bit_sel] = b.bit_value;
			ACT_WR_XER: xer_model = b.value_a;
			default: ;
		endcase
		if (wr_flags)
			cr_model[(7 - tgt) * 4 +: 4] = flags | {3'b0, xer_model[XER_SO_BIT]};
		r.cr_value = cr_model;
		r.xer_value = xer_model;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (cycle_cnt[8:7] == 2'b11 || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic directed(input logic [3:0] act, input logic [31:0] a, input logic [31:0] b,
			input int sa, input int mb, input int me,
			input int fi, input int bi, input int fv, input int bv);
		queued_beat_t q;
		q.drain = 1'b0;
		q.beat = '{act, a, b, 5'(sa), 5'(mb), 5'(me), 3'(fi), 5'(bi), 4'(fv), 1'(bv)};
		pending_beats.push_back(q);
	endtask

	// Sender: offers beats from the queue at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_fire) begin
			if (send_gap > 0) begin
				item_valid <= 1'b0;
				send_gap = send_gap - 1;
			end else if (pending_beats.size() > 0 &&
					!(pending_beats[0].drain && pending_results.size() > 0)) begin
				item <= pending_beats[0].beat;
				item_valid <= 1'b1;
				pending_beats.pop_front();
				send_gap = pick_gap();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once traffic is under way.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (!hold_done && results_seen >= 200) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left = hold_left - 1;
			end else if (recv_gap > 0) begin
				res_ready <= 1'b0;
				recv_gap = recv_gap - 1;
			end else begin
				res_ready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	// Monitor: predicts on each accepted input beat and checks each output beat.
	always @(posedge clk) begin
		srcr_res_t want;
		cycle_cnt = cycle_cnt + 1;
		item_fire = arst_n && item_valid && item_ready;
		if (item_fire) begin
			want = execute_action(item);
			if (item.action == ACT_SRA && want.xer_value[XER_CA_BIT])
				carry_sets = carry_sets + 1;
			pending_results.push_back(want);
			action_hits[item.action] = action_hits[item.action] + 1;
			beats_in = beats_in + 1;
		end
		if (arst_n && res_valid && res_ready) begin
			results_seen = results_seen + 1;
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("ERROR: unexpected result beat %h / %h / %h",
						res.result, res.cr_value, res.xer_value);
				mismatches = mismatches + 1;
			end else begin
				want = pending_results.pop_front();
				if (res.result !== want.result || res.cr_value !== want.cr_value ||
						res.xer_value !== want.xer_value) begin
					if (mismatches < 10)
						$display("ERROR: beat %0d: result %h/%h cr %h/%h xer %h/%h (exp/got)",
							results_seen, want.result, res.result, want.cr_value,
							res.cr_value, want.xer_value, res.xer_value);
					mismatches = mismatches + 1;
				end
			end
		end
	end

	initial begin
		srcr_item_t   b;
		queued_beat_t q;
		int unsigned  counted;
		int unsigned  codes_hit;

		// Directed beats: field extremes, every action and the corner cases.
		directed(ACT_SLL, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
		directed(ACT_SLL, 32'hFFFF_FFFF, 32'hFFFF_FFE0, 31, 31, 31, 7, 31, 15, 1);
		directed(ACT_SLL, 32'h0000_0001, 32'h0000_001F, 0, 0, 0, 0, 0, 0, 0);
		directed(ACT_SRL, 32'hFFFF_FFFF, 32'h0000_003F, 0, 0, 0, 0, 0, 0, 0);
		directed(ACT_SRL, 32'h8000_0000, 32'h0000_0001, 0, 0, 0, 0, 0, 0, 0);
		directed(ACT_SRA, 32'h8000_0001, 32'h0, 1, 0, 0, 0, 0, 0, 0);
		directed(ACT_SRA, 32'h8000_0000, 32'h0, 31, 0, 0, 0, 0, 0, 0);
		directed(ACT_SRA, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 0, 0, 0, 0);
		directed(ACT_SRA, 32'h7FFF_FFFF, 32'h0, 31, 0, 0, 0, 0, 0, 0);
		directed(ACT_ROTL, 32'h8000_0001, 32'h0, 31, 0, 0, 0, 0, 0, 0);
		directed(ACT_MASK, 32'h0, 32'h0, 0, 0, 31, 0, 0, 0, 0);
		directed(ACT_MASK, 32'h0, 32'h0, 0, 31, 0, 0, 0, 0, 0);
		directed(ACT_MASK, 32'h0, 32'h0, 0, 5, 5, 0, 0, 0, 0);
		directed(ACT_WR_XER, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0, 0, 0);
		directed(ACT_CMP_S, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 7, 0, 0, 0);
		directed(ACT_CMP_U, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
		directed(ACT_CMP_S, 32'h1234_5678, 32'h1234_5678, 0, 0, 0, 3, 0, 0, 0);
		directed(ACT_CR0_REC, 32'h0000_0000, 32'h0, 0, 0, 0, 5, 0, 0, 0);
		directed(ACT_WR_XER, 32'h0000_0000, 32'h0, 0, 0, 0, 0, 0, 0, 0);
		directed(ACT_CR0_REC, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0, 0, 0);
		directed(ACT_SET_FIELD, 32'h0, 32'h0, 0, 0, 0, 7, 0, 15, 0);
		directed(ACT_GET_FIELD, 32'h0, 32'h0, 0, 0, 0, 7, 0, 0, 0);
		directed(ACT_SET_BIT, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0, 1);
		directed(ACT_GET_BIT, 32'h0, 32'h0, 0, 0, 0, 0, 31, 0, 0);
		directed(ACT_IDLE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 31, 31, 7, 31, 15, 1);
		directed(ACT_IDLE_LAST, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0, 0);

		// Random beats. The sender drains the unit before the first one and again after the first 300.
		counted = 0;
		while (counted < RANDOM_BEATS) begin
			if ($urandom_range(0, 99) < 4)
				b.action = 4'($urandom_range(ACT_IDLE_FIRST, ACT_IDLE_LAST));
			else
				b.action = 4'($urandom_range(ACT_SLL, ACT_WR_XER));
			b.value_a = pick_operand();
			b.value_b = ($urandom_range(0, 3) == 0) ? b.value_a : pick_operand();
			b.shift_amount = 5'($urandom_range(0, 31));
			b.mask_first = 5'($urandom_range(0, 31));
			b.mask_last = 5'($urandom_range(0, 31));
			b.field_sel = 3'($urandom_range(0, 7));
			b.bit_sel = 5'($urandom_range(0, 31));
			b.field_value = 4'($urandom_range(0, 15));
			b.bit_value = 1'($urandom_range(0, 1));
			q.drain = (counted == 0 || counted == 300);
			q.beat = b;
			pending_beats.push_back(q);
			if (b.action <= ACT_WR_XER)
				counted = counted + 1;
		end

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || item_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		codes_hit = 0;
		foreach (action_hits[i])
			if (action_hits[i] != 0)
				codes_hit = codes_hit + 1;
		$display("Checked %0d result beats for %0d input beats over %0d action codes.",
			results_seen, beats_in, codes_hit);
		$display("Arithmetic shifts set carry %0d times; receiver held off %0d cycles once.",
			carry_sets, HOLD_CYCLES);
		if (mismatches == 0)
			$display("tb_ppc_shift_rotate_compare_cr_unit OK");
		else
			$display("tb_ppc_shift_rotate_compare_cr_unit NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("ERROR: timeout with %0d beats still expected", pending_results.size());
		$display("tb_ppc_shift_rotate_compare_cr_unit NOT OK");
		$finish;
	end

endmodule
